/* rtl/iot_pkg.sv */
// Shared types and constants of the infrared on-off-keyed frame transceiver.
package iot_pkg;

  localparam int unsigned MAX_CHARS_DEF = 32;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned CC_W          = 12;
  localparam int unsigned BIT_W         = 10;
  localparam logic [CC_W-1:0] CARRIER_RESET = 12'd76;

  localparam logic CFG_CARRIER  = 1'b0;
  localparam logic CFG_SAMPLING = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_SEND  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_POLL  = 3'd3,
    CMD_ABORT = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CC_W-1:0] ticks_per_bit;
    logic            sampling_enable;
  } cfg_t;

  typedef struct packed {
    logic              load_overflow;
    logic              rx_frame_end;
    logic [CHAR_W-1:0] rx_char;
    logic              rx_char_valid;
    logic              receiving;
    logic              sending;
    logic              tx_line;
  } res_t;

endpackage

/* rtl/iot_ram.sv */
// Generic simple dual-port RAM with registered read data.
module iot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/iot_engine.sv */
// Transmit and receive sequencer around the character buffer memory.
module iot_engine #(
  parameter int unsigned MAX_CHARS = iot_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic [2:0]                    cmd_i,
  input  logic [iot_pkg::CHAR_W-1:0]    char_i,
  input  logic                          level_i,
  input  iot_pkg::cfg_t                 cfg_i,
  output iot_pkg::res_t                 res_o
);

  localparam int unsigned AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam int unsigned CH = iot_pkg::CHAR_W;
  localparam int unsigned BW = iot_pkg::BIT_W;
  localparam int unsigned TW = iot_pkg::CC_W;

  logic [CW-1:0] tx_count_q, tx_count_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [2:0]    pos_q, pos_d;
  logic [AW-1:0] chr_q, chr_d;
  logic [TW-1:0] tick_q, tick_d;
  logic          phase_q, phase_d;
  logic          line_q, line_d;
  logic          tx_busy_q, tx_busy_d;
  logic          rx_busy_q, rx_busy_d;
  logic [CH-1:0] rx_len_q, rx_len_d;
  logic [CH-1:0] rx_shift_q, rx_shift_d;

  logic          mem_we;
  logic [CH-1:0] mem_rdata;

  logic          tick_last;
  logic [BW-1:0] bit_inc, next_bit, tx_size, rx_size;
  logic [2:0]    adv_pos;
  logic [AW-1:0] adv_chr;
  logic [7:0]    hdr_bits;
  logic          frame_bit;
  logic [CH-1:0] len_new, shift_new;
  logic          rx_done;

  iot_ram #(
    .WIDTH(CH),
    .DEPTH(MAX_CHARS)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(tx_count_q[AW-1:0]),
    .wdata_i(char_i),
    .raddr_i(chr_d),
    .rdata_o(mem_rdata)
  );

  // Bit position bookkeeping shared by both directions.
  always_comb begin
    bit_inc  = bit_q + BW'(1);
    tick_last = (tick_q == (cfg_i.ticks_per_bit - TW'(1)));
    tx_size  = (BW'(tx_count_q) << 3) - BW'(tx_count_q) + BW'(8);
    rx_size  = (BW'(rx_len_q) << 3) - BW'(rx_len_q) + BW'(8);
    if (bit_q < BW'(8)) begin
      adv_pos = 3'd0;
      adv_chr = '0;
    end else if (pos_q == 3'd6) begin
      adv_pos = 3'd0;
      adv_chr = chr_q + AW'(1);
    end else begin
      adv_pos = pos_q + 3'd1;
      adv_chr = chr_q;
    end
    // Start bit on top, then the count MSB first.
    hdr_bits = {1'b1, CH'(tx_count_q)};
    if (bit_q < BW'(8)) begin
      frame_bit = hdr_bits[3'd7 - bit_q[2:0]];
    end else begin
      frame_bit = mem_rdata[3'd6 - pos_q];
    end
    len_new   = {rx_len_q[CH-2:0], level_i};
    shift_new = {rx_shift_q[CH-2:0], level_i};
  end

  always_comb begin
    tx_count_d = tx_count_q;
    bit_d      = bit_q;
    pos_d      = pos_q;
    chr_d      = chr_q;
    tick_d     = tick_q;
    phase_d    = phase_q;
    line_d     = line_q;
    tx_busy_d  = tx_busy_q;
    rx_busy_d  = rx_busy_q;
    rx_len_d   = rx_len_q;
    rx_shift_d = rx_shift_q;
    mem_we     = 1'b0;
    next_bit   = bit_q;
    rx_done    = 1'b0;
    res_o      = '0;

    if (req_i) begin
      case (iot_pkg::cmd_e'(cmd_i))
        iot_pkg::CMD_LOAD: begin
          if (!tx_busy_q) begin
            if (tx_count_q < CW'(MAX_CHARS)) begin
              mem_we     = 1'b1;
              tx_count_d = tx_count_q + CW'(1);
            end else begin
              res_o.load_overflow = 1'b1;
            end
          end
        end
        iot_pkg::CMD_SEND: begin
          if (!tx_busy_q && !rx_busy_q) begin
            tx_busy_d = 1'b1;
            bit_d     = '0;
            tick_d    = '0;
            pos_d     = '0;
            chr_d     = '0;
          end
        end
        iot_pkg::CMD_TICK: begin
          if (tx_busy_q) begin
            if (frame_bit) begin
              line_d  = phase_q;
              phase_d = ~phase_q;
            end else if (tick_q == '0) begin
              line_d = 1'b0;
            end
            if (tick_last) begin
              tick_d   = '0;
              bit_d    = bit_inc;
              pos_d    = adv_pos;
              chr_d    = adv_chr;
              next_bit = bit_inc;
            end else begin
              tick_d = tick_q + TW'(1);
            end
            if (next_bit >= tx_size) begin
              tx_busy_d  = 1'b0;
              bit_d      = '0;
              pos_d      = '0;
              chr_d      = '0;
              tick_d     = '0;
              line_d     = 1'b0;
              tx_count_d = '0;
            end
          end else if (rx_busy_q) begin
            if (bit_q == '0) begin
              rx_len_d = '0;
            end else if (bit_q < BW'(8)) begin
              rx_len_d = len_new;
              rx_done  = (bit_q == BW'(7)) && (len_new == '0);
            end else begin
              rx_shift_d = shift_new;
              if (pos_q == 3'd6) begin
                res_o.rx_char_valid = 1'b1;
                res_o.rx_char       = shift_new;
                rx_shift_d          = '0;
              end
              rx_done = (bit_inc >= rx_size);
            end
            bit_d = bit_inc;
            pos_d = adv_pos;
            chr_d = adv_chr;
            if (rx_done) begin
              res_o.rx_frame_end = 1'b1;
              rx_busy_d  = 1'b0;
              bit_d      = '0;
              pos_d      = '0;
              chr_d      = '0;
              rx_shift_d = '0;
            end
          end
        end
        iot_pkg::CMD_POLL: begin
          if (cfg_i.sampling_enable && level_i && !rx_busy_q && !tx_busy_q) begin
            rx_busy_d  = 1'b1;
            bit_d      = '0;
            pos_d      = '0;
            chr_d      = '0;
            rx_len_d   = '0;
            rx_shift_d = '0;
          end
        end
        iot_pkg::CMD_ABORT: begin
          if (rx_busy_q) begin
            rx_busy_d  = 1'b0;
            bit_d      = '0;
            pos_d      = '0;
            chr_d      = '0;
            rx_len_d   = '0;
            rx_shift_d = '0;
          end
        end
        default: begin
        end
      endcase
    end

    res_o.tx_line   = line_d;
    res_o.sending   = tx_busy_d;
    res_o.receiving = rx_busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_count_q <= '0;
      bit_q      <= '0;
      pos_q      <= '0;
      chr_q      <= '0;
      tick_q     <= '0;
      phase_q    <= 1'b1;
      line_q     <= 1'b0;
      tx_busy_q  <= 1'b0;
      rx_busy_q  <= 1'b0;
      rx_len_q   <= '0;
      rx_shift_q <= '0;
    end else begin
      tx_count_q <= tx_count_d;
      bit_q      <= bit_d;
      pos_q      <= pos_d;
      chr_q      <= chr_d;
      tick_q     <= tick_d;
      phase_q    <= phase_d;
      line_q     <= line_d;
      tx_busy_q  <= tx_busy_d;
      rx_busy_q  <= rx_busy_d;
      rx_len_q   <= rx_len_d;
      rx_shift_q <= rx_shift_d;
    end
  end

endmodule

/* rtl/ir_ook_frame_transceiver.sv */
// A request's result sits in the output register in the cycle after acceptance.
// Throughput: one request per cycle unless the output stalls; buffer reads run ahead of use.
// The output register refills in the cycle it is drained, so there are no bubbles.
// Reset is asynchronous, active low: control state, the output valid flag and both
// configuration registers take reset values.
// The character buffer is not cleared; it holds valid data only after loads.
module ir_ook_frame_transceiver #(
  parameter int unsigned MAX_CHARS = iot_pkg::MAX_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_value[6:0], rx_level[7]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_line[0], sending[1], receiving[2], rx_char_valid[3], rx_char[10:4],
  // load_overflow[11], zero fill[15:12]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,  // rx_frame_end
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i
);

  iot_pkg::cfg_t cfg_q, cfg_d;
  iot_pkg::res_t res;
  iot_pkg::res_t out_q;
  logic          out_valid_q, out_valid_d;
  logic          req;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign req           = s_axis_tvalid && s_axis_tready;

  iot_engine #(
    .MAX_CHARS(MAX_CHARS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cmd_i  (s_axis_tuser),
    .char_i (s_axis_tdata[6:0]),
    .level_i(s_axis_tdata[7]),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        iot_pkg::CFG_CARRIER:  cfg_d.ticks_per_bit   = cfg_wdata_i;
        iot_pkg::CFG_SAMPLING: cfg_d.sampling_enable = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (req) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_bit   <= iot_pkg::CARRIER_RESET;
      cfg_q.sampling_enable <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.load_overflow, out_q.rx_char, out_q.rx_char_valid,
                          out_q.receiving, out_q.sending, out_q.tx_line};
  assign m_axis_tlast  = out_q.rx_frame_end;

`ifndef NO_ASSERTIONS
  a_not_both_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("sending and receiving at once");

  a_frame_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[2])
    else $error("receiver still busy after frame end");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> (m_axis_tdata[10:4] == 7'd0))
    else $error("received character without valid flag");

  a_ovf_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[11]) |-> !m_axis_tdata[1])
    else $error("overflow flagged while sending");
`endif

endmodule
